// ===== rtl/npsh_pkg.sv =====
// Shared types, constants and constant tables for the nearest-point haversine search.
`default_nettype none
package npsh_pkg;

  localparam int TRIG_F = 16;
  localparam int ANGLE_W = 22;
  localparam int TRIG_W = 18;
  localparam int LAT_W = 18;
  localparam int LON_W = 19;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int METRIC_W = 32;

  localparam int TURN_UNITS = 720000;
  localparam int HALF_UNITS = 360000;
  localparam int QUARTER_UNITS = 180000;

  // The angle to Q30 scaling is m * 9370 + floor(m * 59426 / 360000).
  localparam logic [31:0] T_WHOLE_MUL = 32'd9370;
  localparam logic [31:0] T_FRAC_MUL = 32'd59426;
  localparam logic [31:0] T_FRAC_RECIP = 32'd390937468;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [TRIG_W-2:0] trig_mag_t;

  typedef struct packed {
    logic   start;
    angle_t angle;
  } sin_req_t;

  typedef struct packed {
    logic  done;
    trig_t value;
  } sin_rsp_t;

  typedef struct packed {
    logic  start;
    trig_t sin_lat;
    trig_t sin_lon;
    trig_t cos_query;
    trig_t cos_point;
  } met_req_t;

  typedef struct packed {
    logic                done;
    logic [METRIC_W-1:0] metric;
  } met_rsp_t;

  // Reciprocal of the odd part of 2k(2k+1) for series term k.
  function automatic logic [31:0] sin_recip(input logic [2:0] k);
    logic [31:0] r;
    case (k)
      3'd7: r = 32'd2617884829;
      3'd6: r = 32'd3524075731;
      3'd5: r = 32'd2498890064;
      3'd4: r = 32'd3817748708;
      3'd3: r = 32'd3272356036;
      3'd2: r = 32'd3435973837;
      3'd1: r = 32'd2863311531;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Power of two in 2k(2k+1), removed before the reciprocal multiply.
  function automatic logic [1:0] sin_pre_shift(input logic [2:0] k);
    logic [1:0] s;
    case (k)
      3'd6: s = 2'd2;
      3'd4: s = 2'd3;
      3'd2: s = 2'd2;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

  // Shift that completes the reciprocal multiply for series term k.
  function automatic logic [5:0] sin_post_shift(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd7: s = 6'd38;
      3'd6: s = 6'd37;
      3'd5: s = 6'd37;
      3'd4: s = 6'd35;
      3'd3: s = 6'd36;
      3'd2: s = 6'd34;
      3'd1: s = 6'd33;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic trig_mag_t trig_mag(input trig_t v);
    trig_t n;
    n = -v;
    return v[TRIG_W-1] ? n[TRIG_W-2:0] : v[TRIG_W-2:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/npsh_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module npsh_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/npsh_sin.sv =====
// Iterative fixed-point sine unit built around one shared 32x32 multiplier.
`default_nettype none
module npsh_sin
  import npsh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire sin_req_t req,
  output sin_rsp_t      rsp
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_T1   = 4'd2;
  localparam logic [3:0] S_T2   = 4'd3;
  localparam logic [3:0] S_T3   = 4'd4;
  localparam logic [3:0] S_T4   = 4'd5;
  localparam logic [3:0] S_T5   = 4'd6;
  localparam logic [3:0] S_T6   = 4'd7;
  localparam logic [3:0] S_L1   = 4'd8;
  localparam logic [3:0] S_L2   = 4'd9;
  localparam logic [3:0] S_L3   = 4'd10;
  localparam logic [3:0] S_F1   = 4'd11;
  localparam logic [3:0] S_F2   = 4'd12;

  localparam angle_t A_TURN = angle_t'(TURN_UNITS);
  localparam angle_t A_HALF = angle_t'(HALF_UNITS);
  localparam angle_t A_QUARTER = angle_t'(QUARTER_UNITS);
  localparam logic [30:0] ROUND_HALF = 31'(1) << (29 - TRIG_F);

  logic [3:0]  state;
  angle_t      m;
  logic        neg;
  logic [15:0] q1;
  logic [30:0] t;
  logic [31:0] t2;
  logic [30:0] r;
  logic [2:0]  k;
  logic [63:0] prod;
  logic [31:0] ma;
  logic [31:0] mb;
  angle_t      m_half;
  angle_t      m_fold;
  logic [31:0] p_top;
  logic [63:0] quo;
  logic [30:0] s_val;
  logic [30:0] s_round;
  logic [TRIG_W-2:0] q_mag;

  always_comb begin
    m_half = (m >= A_HALF) ? m - A_HALF : m;
    m_fold = (m_half > A_QUARTER) ? A_HALF - m_half : m_half;
    p_top = prod[61:30];
    quo = prod >> sin_post_shift(k);
    s_val = prod[60:30];
    s_round = s_val + ROUND_HALF;
    q_mag = (TRIG_W-1)'(s_round >> (30 - TRIG_F));
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_T1: begin
        ma = 32'(m[17:0]);
        mb = T_FRAC_MUL;
      end
      S_T2: begin
        ma = 32'(prod[33:6]);
        mb = T_FRAC_RECIP;
      end
      S_T3: begin
        ma = 32'(m[17:0]);
        mb = T_WHOLE_MUL;
      end
      S_T5: begin
        ma = 32'(t);
        mb = 32'(t);
      end
      S_L1: begin
        ma = t2;
        mb = 32'(r);
      end
      S_L2: begin
        ma = p_top >> sin_pre_shift(k);
        mb = sin_recip(k);
      end
      S_F1: begin
        ma = 32'(t);
        mb = 32'(r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == S_F2);
      case (state)
        S_IDLE: begin
          if (req.start) begin
            m <= req.angle;
            state <= S_RED;
          end
        end
        S_RED: begin
          if (m < 0) begin
            m <= m + A_TURN;
          end else if (m >= A_TURN) begin
            m <= m - A_TURN;
          end else begin
            neg <= (m >= A_HALF);
            m <= m_fold;
            state <= S_T1;
          end
        end
        S_T1: state <= S_T2;
        S_T2: state <= S_T3;
        S_T3: begin
          q1 <= prod[56:41];
          state <= S_T4;
        end
        S_T4: begin
          t <= prod[30:0] + 31'(q1);
          state <= S_T5;
        end
        S_T5: state <= S_T6;
        S_T6: begin
          t2 <= p_top;
          r <= ONE_Q30;
          k <= 3'd7;
          state <= S_L1;
        end
        S_L1: state <= S_L2;
        S_L2: state <= S_L3;
        S_L3: begin
          r <= ONE_Q30 - quo[30:0];
          if (k == 3'd1) begin
            state <= S_F1;
          end else begin
            k <= k - 3'd1;
            state <= S_L1;
          end
        end
        S_F1: state <= S_F2;
        S_F2: begin
          rsp.value <= neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/npsh_metric.sv =====
// Haversine term from the two sines and the two cosines, on one shared multiplier.
`default_nettype none
module npsh_metric
  import npsh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire met_req_t req,
  output met_rsp_t      rsp
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_P1   = 3'd1;
  localparam logic [2:0] M_P2   = 3'd2;
  localparam logic [2:0] M_P3   = 3'd3;
  localparam logic [2:0] M_P4   = 3'd4;
  localparam logic [2:0] M_P5   = 3'd5;
  localparam logic [2:0] M_P6   = 3'd6;

  logic [2:0]  state;
  logic        ccneg;
  logic [31:0] term1;
  logic [31:0] slon;
  logic [31:0] term2;
  logic [63:0] prod;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] rounded;
  logic [32:0] sum;
  logic [31:0] result;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      M_P1: begin
        ma = 32'(trig_mag(req.sin_lat));
        mb = 32'(trig_mag(req.sin_lat));
      end
      M_P2: begin
        ma = 32'(trig_mag(req.sin_lon));
        mb = 32'(trig_mag(req.sin_lon));
      end
      M_P3: begin
        ma = 32'(trig_mag(req.cos_query));
        mb = 32'(trig_mag(req.cos_point));
      end
      M_P4: begin
        ma = sat32(prod);
        mb = slon;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    rounded = prod + 64'h8000_0000;
    sum = 33'(term1) + 33'(term2);
    if (ccneg) begin
      result = (term2 >= term1) ? 32'd0 : term1 - term2;
    end else begin
      result = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == M_P6);
      case (state)
        M_IDLE: begin
          if (req.start) begin
            ccneg <= (req.cos_query[TRIG_W-1] ^ req.cos_point[TRIG_W-1]) &&
                     (req.cos_query != '0) && (req.cos_point != '0);
            state <= M_P1;
          end
        end
        M_P1: state <= M_P2;
        M_P2: begin
          term1 <= sat32(prod);
          state <= M_P3;
        end
        M_P3: begin
          slon <= sat32(prod);
          state <= M_P4;
        end
        M_P4: state <= M_P5;
        M_P5: begin
          term2 <= rounded[63:32];
          state <= M_P6;
        end
        M_P6: begin
          rsp.metric <= result;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nearest_point_haversine_search.sv =====
// Top level of the nearest-point haversine search: point table, query sequencer, result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    command, point_index, latitude, longitude
//   out      output     out_valid / out_ready  nearest_index, nearest_metric
//   cfg      input      cfg_valid / cfg_ready  cfg_data (point_count)
//
// A load is accepted whenever the sequencer is idle. A query computes the query cosine, then
// for each searched point performs one table read, three passes through the sine unit (each
// running its seven-term series loop), one metric pass and one update.
// Reset is synchronous and restores point_count to 50; the table is not cleared.
// A finished result waits in the output register; loads are taken meanwhile, and a
// following query stalls only at its end until the previous result has been taken.
`default_nettype none
module nearest_point_haversine_search
  import npsh_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      command,
  input  wire logic [INDEX_W-1:0]        point_index,
  input  wire logic signed [LAT_W-1:0]   latitude,
  input  wire logic signed [LON_W-1:0]   longitude,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [INDEX_W-1:0]             nearest_index,
  output logic [METRIC_W-1:0]            nearest_metric,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [COUNT_W-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] Q_IDLE = 4'd0;
  localparam logic [3:0] Q_C1   = 4'd1;
  localparam logic [3:0] Q_RD   = 4'd2;
  localparam logic [3:0] Q_SL   = 4'd3;
  localparam logic [3:0] Q_SO   = 4'd4;
  localparam logic [3:0] Q_C2   = 4'd5;
  localparam logic [3:0] Q_MET  = 4'd6;
  localparam logic [3:0] Q_UPD  = 4'd7;
  localparam logic [3:0] Q_FIN  = 4'd8;

  logic [3:0]              state;
  logic [COUNT_W-1:0]      point_count;
  logic signed [LAT_W-1:0] q_lat;
  logic signed [LON_W-1:0] q_lon;
  logic [CW-1:0]           n;
  logic [CW-1:0]           count_clamped;
  logic [AW-1:0]           idx;
  trig_t                   c1;
  trig_t                   sl;
  trig_t                   so;
  trig_t                   c2;
  logic [METRIC_W-1:0]     best_metric;
  logic [AW-1:0]           best_idx;
  logic                    sub_wait;
  logic                    in_fire;
  logic                    load_we;
  logic signed [LAT_W-1:0] rd_lat;
  logic signed [LON_W-1:0] rd_lon;
  sin_req_t                sin_req;
  sin_rsp_t                sin_rsp;
  met_req_t                met_req;
  met_rsp_t                met_rsp;
  angle_t                  quarter;

  assign in_ready = (state == Q_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign load_we = in_fire && (command == CMD_LOAD) && (32'(point_index) < MAX_POINTS);
  assign quarter = angle_t'(QUARTER_UNITS);

  always_comb begin
    if (point_count == '0) begin
      count_clamped = CW'(1);
    end else if (32'(point_count) > MAX_POINTS) begin
      count_clamped = CW'(MAX_POINTS);
    end else begin
      count_clamped = CW'(point_count);
    end
  end

  npsh_ram #(.WIDTH(LAT_W), .DEPTH(MAX_POINTS)) u_lat_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(point_index)),
    .wdata (latitude),
    .re    (state == Q_RD),
    .raddr (idx),
    .rdata (rd_lat)
  );

  npsh_ram #(.WIDTH(LON_W), .DEPTH(MAX_POINTS)) u_lon_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(point_index)),
    .wdata (longitude),
    .re    (state == Q_RD),
    .raddr (idx),
    .rdata (rd_lon)
  );

  always_comb begin
    sin_req.start = 1'b0;
    sin_req.angle = '0;
    case (state)
      Q_C1: begin
        sin_req.start = !sub_wait;
        sin_req.angle = (angle_t'(q_lat) <<< 1) + quarter;
      end
      Q_SL: begin
        sin_req.start = !sub_wait;
        sin_req.angle = angle_t'(rd_lat) - angle_t'(q_lat);
      end
      Q_SO: begin
        sin_req.start = !sub_wait;
        sin_req.angle = angle_t'(rd_lon) - angle_t'(q_lon);
      end
      Q_C2: begin
        sin_req.start = !sub_wait;
        sin_req.angle = (angle_t'(rd_lat) <<< 1) + quarter;
      end
      default: begin
        sin_req.start = 1'b0;
        sin_req.angle = '0;
      end
    endcase
  end

  always_comb begin
    met_req.start = (state == Q_MET) && !sub_wait;
    met_req.sin_lat = sl;
    met_req.sin_lon = so;
    met_req.cos_query = c1;
    met_req.cos_point = c2;
  end

  npsh_sin u_sin (
    .clk (clk),
    .rst (rst),
    .req (sin_req),
    .rsp (sin_rsp)
  );

  npsh_metric u_metric (
    .clk (clk),
    .rst (rst),
    .req (met_req),
    .rsp (met_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      point_count <= COUNT_W'(50);
      sub_wait <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
      if (out_valid && out_ready && (state != Q_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        Q_IDLE: begin
          if (in_fire && (command == CMD_QUERY)) begin
            q_lat <= latitude;
            q_lon <= longitude;
            n <= count_clamped;
            state <= Q_C1;
          end
        end
        Q_C1: begin
          sub_wait <= !sin_rsp.done;
          if (sin_rsp.done) begin
            c1 <= sin_rsp.value;
            idx <= '0;
            state <= Q_RD;
          end
        end
        Q_RD: state <= Q_SL;
        Q_SL: begin
          sub_wait <= !sin_rsp.done;
          if (sin_rsp.done) begin
            sl <= sin_rsp.value;
            state <= Q_SO;
          end
        end
        Q_SO: begin
          sub_wait <= !sin_rsp.done;
          if (sin_rsp.done) begin
            so <= sin_rsp.value;
            state <= Q_C2;
          end
        end
        Q_C2: begin
          sub_wait <= !sin_rsp.done;
          if (sin_rsp.done) begin
            c2 <= sin_rsp.value;
            state <= Q_MET;
          end
        end
        Q_MET: begin
          sub_wait <= !met_rsp.done;
          if (met_rsp.done) begin
            state <= Q_UPD;
          end
        end
        Q_UPD: begin
          if ((idx == '0) || (met_rsp.metric < best_metric)) begin
            best_metric <= met_rsp.metric;
            best_idx <= idx;
          end
          if (CW'(idx) == n - CW'(1)) begin
            state <= Q_FIN;
          end else begin
            idx <= idx + AW'(1);
            state <= Q_RD;
          end
        end
        Q_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            nearest_index <= INDEX_W'(best_idx);
            nearest_metric <= best_metric;
            state <= Q_IDLE;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== test/nearest_point_haversine_search_test.sv =====
// Self-checking testbench for the nearest-point haversine search block.
`timescale 1ns / 100ps
module nearest_point_haversine_search_test;
  import npsh_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 52;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [METRIC_W-1:0] metric;
  } nearest_t;

  typedef struct {
    logic cmd;
    logic [INDEX_W-1:0] idx;
    int lat;
    int lon;
    bit typed;
    logic [INDEX_W-1:0] want_idx;
    logic [METRIC_W-1:0] want_metric;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_LOAD;
  logic [INDEX_W-1:0] point_index = '0;
  logic signed [LAT_W-1:0] latitude = '0;
  logic signed [LON_W-1:0] longitude = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_W-1:0] nearest_index;
  logic [METRIC_W-1:0] nearest_metric;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  nearest_point_haversine_search u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .point_index(point_index), .latitude(latitude), .longitude(longitude),
    .out_valid(out_valid), .out_ready(out_ready),
    .nearest_index(nearest_index), .nearest_metric(nearest_metric),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  longint table_lat[64];
  longint table_lon[64];
  logic [COUNT_W-1:0] search_count;
  nearest_t pending_nearest[$];
  int failures = 0;
  int mismatches = 0;
  int results_seen = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  bit no_idle = 0;
  int idle_cycles = 0;

  function automatic longint sine_of(longint a);
    longint m;
    bit neg;
    longint unsigned t, t2, r, s, q;
    m = a % 720000;
    neg = 0;
    if (m < 0) m += 720000;
    if (m >= 360000) begin
      neg = 1;
      m -= 360000;
    end
    if (m > 180000) m = 360000 - m;
    t = (longint'(m) * 64'd3373259426) / 64'd360000;
    t2 = (t * t) >> 30;
    r = 64'd1 << 30;
    for (int k = 7; k >= 1; k--) begin
      r = (64'd1 << 30) - ((t2 * r) >> 30) / longint'((2 * k) * (2 * k + 1));
    end
    s = (t * r) >> 30;
    q = (s + (64'd1 << (29 - TRIG_F))) >> (30 - TRIG_F);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned sat_q32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic logic [31:0] haversine_term(longint lat1, longint lon1,
                                                 longint lat2, longint lon2);
    longint sl, so, c1, c2, cc;
    longint unsigned term1, slon, ccm, term2;
    sl = sine_of(lat2 - lat1);
    so = sine_of(lon2 - lon1);
    c1 = sine_of(2 * lat1 + 180000);
    c2 = sine_of(2 * lat2 + 180000);
    term1 = sat_q32(longint'(sl * sl));
    slon = sat_q32(longint'(so * so));
    cc = c1 * c2;
    ccm = sat_q32(cc < 0 ? -cc : cc);
    term2 = (ccm * slon + (64'd1 << 31)) >> 32;
    if (cc < 0) return (term2 >= term1) ? 32'd0 : 32'(term1 - term2);
    return 32'(sat_q32(term1 + term2));
  endfunction

  function automatic nearest_t nearest_of(longint lat, longint lon);
    nearest_t best;
    int n;
    logic [31:0] d;
    n = search_count;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    best.idx = '0;
    best.metric = haversine_term(lat, lon, table_lat[0], table_lon[0]);
    for (int i = 1; i < n; i++) begin
      d = haversine_term(lat, lon, table_lat[i], table_lon[i]);
      if (d < best.metric) begin
        best.metric = d;
        best.idx = INDEX_W'(i);
      end
    end
    return best;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(logic cmd, logic [INDEX_W-1:0] idx, int lat, int lon,
                              bit typed, nearest_t want);
    int gap;
    nearest_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    point_index <= idx;
    latitude <= LAT_W'(lat);
    longitude <= LON_W'(lon);
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD) begin
      table_lat[idx] = longint'($signed(LAT_W'(lat)));
      table_lon[idx] = longint'($signed(LON_W'(lon)));
      loads_sent++;
    end else begin
      got = nearest_of(longint'($signed(LAT_W'(lat))), longint'($signed(LON_W'(lon))));
      if (typed && got != want) begin
        failures++;
        $display("typed expectation disagrees with predictor: idx %0d/%0d metric %h/%h",
                 want.idx, got.idx, want.metric, got.metric);
      end
      pending_nearest.push_back(typed ? want : got);
      queries_sent++;
    end
  endtask

  task automatic write_count(logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    wait (pending_nearest.size() == 0);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    search_count = value;
  endtask

  function automatic int random_lat();
    if ($urandom_range(0, 9) == 0) return int'($signed(18'($urandom)));
    return $urandom_range(0, 180000) - 90000;
  endfunction

  function automatic int random_lon();
    if ($urandom_range(0, 9) == 0) return int'($signed(19'($urandom)));
    return $urandom_range(0, 360000) - 180000;
  endfunction

  always @(posedge clk) begin
    nearest_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_nearest.size() == 0) begin
        failures++;
        $display("unexpected result: index %0d metric %h", nearest_index, nearest_metric);
      end else begin
        want = pending_nearest.pop_front();
        if (want.idx !== nearest_index || want.metric !== nearest_metric) begin
          failures++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: index exp %0d got %0d, metric exp %h got %h",
                     want.idx, nearest_index, want.metric, nearest_metric);
        end
      end
    end
  end

  initial begin
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      if (!held && results_seen >= 30) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 49) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 9) < 7);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    logic [COUNT_W-1:0] phase_count[N_PHASES];
    nearest_t want;
    int pct;
    phase_count = '{1, 0, 64, 3, 127, 2, 8, 65, 4, 16, 1, 6};
    search_count = 7'd50;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 64; i++) begin
      send_request(CMD_LOAD, INDEX_W'(i), random_lat(), random_lon(), 0, want);
    end

    rows = '{
      '{CMD_LOAD, 6'd0, 0, 0, 0, 0, 0},
      '{CMD_QUERY, 6'd9, 0, 0, 1, 6'd0, 32'd0},
      '{CMD_LOAD, 6'd1, 90000, 180000, 0, 0, 0},
      '{CMD_LOAD, 6'd2, -90000, -180000, 0, 0, 0},
      '{CMD_QUERY, 6'd63, 90000, 180000, 1, 6'd1, 32'd0},
      '{CMD_QUERY, 6'd0, -90000, -180000, 1, 6'd2, 32'd0},
      '{CMD_LOAD, 6'd3, 131071, 262143, 0, 0, 0},
      '{CMD_LOAD, 6'd4, -131072, -262144, 0, 0, 0},
      '{CMD_LOAD, 6'd63, 45000, -90000, 0, 0, 0},
      '{CMD_QUERY, 6'd0, 131071, 262143, 0, 0, 0},
      '{CMD_QUERY, 6'd0, -131072, -262144, 0, 0, 0},
      '{CMD_QUERY, 6'd0, -90000, 0, 0, 0, 0},
      '{CMD_QUERY, 6'd0, 0, 180000, 0, 0, 0}
    };
    foreach (rows[r]) begin
      want.idx = rows[r].want_idx;
      want.metric = rows[r].want_metric;
      send_request(rows[r].cmd, rows[r].idx, rows[r].lat, rows[r].lon, rows[r].typed, want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_count(phase_count[p]);
      no_idle = (p % 4 == 3);
      pct = (phase_count[p] > 16) ? 5 : 40;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < pct)
          send_request(CMD_QUERY, INDEX_W'($urandom), random_lat(), random_lon(), 0, want);
        else
          send_request(CMD_LOAD, INDEX_W'($urandom), random_lat(), random_lon(), 0, want);
      end
    end
    no_idle = 0;
    in_valid <= 1'b0;

    wait (pending_nearest.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d loads and %0d queries over %0d search-count settings.",
             loads_sent, queries_sent, N_PHASES + 1);
    $display("Checked %0d results, %0d failures.", results_seen, failures);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
